// ----- rtl/rpd_pkg.sv -----
// rpd_pkg: shared types and constants for the response packet deframer
// no dependencies
package rpd_pkg;

    localparam int unsigned MAX_PAYLOAD_DEF = 256;

    localparam logic [7:0] HDR_BYTE0 = 8'hEF;
    localparam logic [7:0] HDR_BYTE1 = 8'h01;
    localparam logic [7:0] IDENT_BYTE = 8'h07;
    localparam int unsigned LEN_OVERHEAD = 3;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_ABORT = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_HDR   = 3'd1,
        ST_BAD_IDENT = 3'd2,
        ST_BAD_LEN   = 3'd3,
        ST_BAD_SUM   = 3'd4,
        ST_TRUNC     = 3'd5
    } status_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] confirm_code;
        logic [8:0] payload_count;
        logic [2:0] status;
    } result_t;

endpackage

// ----- rtl/response_packet_deframer.sv -----
// response_packet_deframer: top level, input register, parser and result buffer
// depends on rpd_pkg, rpd_parser, rpd_out_queue
//
// usage
//   input channel: valid/ready with op and rx_byte; op selects a received byte
//   or an abort that ends the current frame
//   output channel: valid/ready with kind, payload_byte, confirm_code,
//   payload_count and status; one payload transaction per payload byte and
//   one status transaction per finished, failed or aborted frame
//   path: a transaction that yields a result passes the input register, then
//   the result buffer, before it shows on the output; a full buffer with a
//   stalled output can hold it in the input register between the two
//   throughput: one input transaction per cycle while the result buffer has
//   space, set by the parser step between the input register and the buffer
//   reset: asynchronous, clears the parser to header hunting and empties
//   the input register and the two-entry result buffer
//   stall: while the output is stalled, the buffer fills; the parser holds
//   its input register once the buffer is full and ready drops
//   MAX_PAYLOAD bounds the accepted payload length per frame
module response_packet_deframer #(
    parameter int unsigned MAX_PAYLOAD = rpd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       op,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       kind,
    output logic [7:0] payload_byte,
    output logic [7:0] confirm_code,
    output logic [8:0] payload_count,
    output logic [2:0] status
);
    import rpd_pkg::*;

    logic       s1_valid_reg;
    logic       s1_op_reg;
    logic [7:0] s1_byte_reg;
    logic       step;
    logic       space;
    logic       res_valid;
    result_t    res;
    result_t    out_data;

    assign step = s1_valid_reg && space;
    assign in_ready = !s1_valid_reg || space;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else if (in_ready) begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            s1_op_reg <= op;
            s1_byte_reg <= rx_byte;
        end
    end

    rpd_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item_op   (s1_op_reg),
        .item_byte (s1_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    rpd_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign kind = out_data.kind;
    assign payload_byte = out_data.payload_byte;
    assign confirm_code = out_data.confirm_code;
    assign payload_count = out_data.payload_count;
    assign status = out_data.status;

endmodule

// ----- rtl/rpd_parser.sv -----
// rpd_parser: frame state machine, consumes one transaction per enabled cycle
// depends on rpd_pkg
module rpd_parser #(
    parameter int unsigned MAX_PAYLOAD = rpd_pkg::MAX_PAYLOAD_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             item_op,
    input  logic [7:0]       item_byte,
    output logic             res_valid,
    output rpd_pkg::result_t res
);
    import rpd_pkg::*;

    localparam int unsigned LEFT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [16:0] LEN_MAX = 17'(MAX_PAYLOAD + LEN_OVERHEAD);
    localparam logic [16:0] LEN_MIN = 17'(LEN_OVERHEAD);

    typedef enum logic [3:0] {
        HUNT, HDR1, ADDR0, ADDR1, ADDR2, ADDR3, IDENT,
        LENH, LENL, CONF, PAYLOAD, CSH, CSL
    } pos_t;

    pos_t              pos_reg, pos_next;
    logic [7:0]        len_hi_reg, len_hi_next;
    logic [LEFT_W-1:0] left_reg, left_next;
    logic [15:0]       sum_reg, sum_next;
    logic [7:0]        conf_reg, conf_next;
    logic [7:0]        cs_hi_reg, cs_hi_next;
    logic [8:0]        sent_reg, sent_next;
    logic [16:0]       len_full;
    logic [16:0]       len_minus;

    assign len_full = {1'b0, len_hi_reg, item_byte};
    assign len_minus = len_full - LEN_MIN;

    always_comb
    begin
        pos_next = pos_reg;
        len_hi_next = len_hi_reg;
        left_next = left_reg;
        sum_next = sum_reg;
        conf_next = conf_reg;
        cs_hi_next = cs_hi_reg;
        sent_next = sent_reg;
        res_valid = 1'b0;
        res = '0;
        res.kind = KIND_STATUS;
        if (item_op == OP_ABORT) begin
            if (pos_reg != HUNT) begin
                res_valid = 1'b1;
                res.status = ST_TRUNC;
                if (pos_reg == PAYLOAD || pos_reg == CSH || pos_reg == CSL) begin
                    res.confirm_code = conf_reg;
                    res.payload_count = sent_reg;
                end
            end
            pos_next = HUNT;
        end else begin
            unique case (pos_reg)
                HDR1:
                begin
                    if (item_byte != HDR_BYTE1) begin
                        res_valid = 1'b1;
                        res.status = ST_BAD_HDR;
                        pos_next = HUNT;
                    end else begin
                        pos_next = ADDR0;
                    end
                end
                ADDR0: pos_next = ADDR1;
                ADDR1: pos_next = ADDR2;
                ADDR2: pos_next = ADDR3;
                ADDR3: pos_next = IDENT;
                IDENT:
                begin
                    if (item_byte != IDENT_BYTE) begin
                        res_valid = 1'b1;
                        res.status = ST_BAD_IDENT;
                        pos_next = HUNT;
                    end else begin
                        pos_next = LENH;
                    end
                end
                LENH:
                begin
                    len_hi_next = item_byte;
                    pos_next = LENL;
                end
                LENL:
                begin
                    if (len_full < LEN_MIN || len_full > LEN_MAX) begin
                        res_valid = 1'b1;
                        res.status = ST_BAD_LEN;
                        pos_next = HUNT;
                    end else begin
                        left_next = len_minus[LEFT_W-1:0];
                        pos_next = CONF;
                    end
                end
                CONF:
                begin
                    conf_next = item_byte;
                    sum_next = {8'd0, item_byte};
                    sent_next = '0;
                    pos_next = (left_reg == '0) ? CSH : PAYLOAD;
                end
                PAYLOAD:
                begin
                    sum_next = sum_reg + {8'd0, item_byte};
                    left_next = left_reg - LEFT_W'(1);
                    sent_next = sent_reg + 9'd1;
                    if (left_reg == LEFT_W'(1)) begin
                        pos_next = CSH;
                    end
                    res_valid = 1'b1;
                    res.kind = KIND_PAYLOAD;
                    res.payload_byte = item_byte;
                end
                CSH:
                begin
                    cs_hi_next = item_byte;
                    pos_next = CSL;
                end
                CSL:
                begin
                    res_valid = 1'b1;
                    res.confirm_code = conf_reg;
                    res.payload_count = sent_reg;
                    res.status = ({cs_hi_reg, item_byte} == sum_reg) ? ST_OK : ST_BAD_SUM;
                    pos_next = HUNT;
                end
                default:
                begin
                    if (item_byte == HDR_BYTE0) begin
                        conf_next = '0;
                        sum_next = '0;
                        left_next = '0;
                        len_hi_next = '0;
                        cs_hi_next = '0;
                        sent_next = '0;
                        pos_next = HDR1;
                    end else begin
                        pos_next = HUNT;
                    end
                end
            endcase
        end
        if (!step) begin
            res_valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= HUNT;
            len_hi_reg <= '0;
            left_reg <= '0;
            sum_reg <= '0;
            conf_reg <= '0;
            cs_hi_reg <= '0;
            sent_reg <= '0;
        end else if (step) begin
            pos_reg <= pos_next;
            len_hi_reg <= len_hi_next;
            left_reg <= left_next;
            sum_reg <= sum_next;
            conf_reg <= conf_next;
            cs_hi_reg <= cs_hi_next;
            sent_reg <= sent_next;
        end
    end

endmodule

// ----- rtl/rpd_out_queue.sv -----
// rpd_out_queue: two-entry result buffer feeding the output channel
// depends on rpd_pkg
module rpd_out_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  rpd_pkg::result_t push_data,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output rpd_pkg::result_t out_data
);
    import rpd_pkg::*;

    logic [1:0] count_reg, count_next;
    result_t    entry0_reg;
    result_t    entry1_reg;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign out_data = entry0_reg;
    assign pop = out_valid && out_ready;
    assign space = (count_reg != 2'd2) || out_ready;

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            if (count_reg == 2'd2) begin
                entry0_reg <= entry1_reg;
                if (push) begin
                    entry1_reg <= push_data;
                end
            end else if (push) begin
                entry0_reg <= push_data;
            end
        end else if (push) begin
            if (count_reg == 2'd0) begin
                entry0_reg <= push_data;
            end else begin
                entry1_reg <= push_data;
            end
        end
    end

endmodule
